@@ hw/rtl/mhpq_pkg.sv @@
// Shared types and codes for the max-heap priority queue.
package mhpq_pkg;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int unsigned TOTAL_W = 11;

    // One stored heap entry
    typedef struct packed {
        logic signed [31:0] key;
        logic [31:0]        tag;
    } mhpq_entry_t;

    // One finished result
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_key;
        logic [31:0]        removed_tag;
        logic               top_valid;
        logic signed [31:0] top_key;
        logic [31:0]        top_tag;
        logic [TOTAL_W-1:0] entry_total;
    } mhpq_res_t;

endpackage

@@ hw/rtl/max_heap_priority_queue.sv @@
// Top level of the binary max-heap priority queue with its result register.
//
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid/in_ready    opcode, key, tag
//  out      output     out_valid/out_ready  status, removed_key, removed_tag,
//                                           top_valid, top_key, top_tag, entry_total
//
// Insert: each parent is read and compared, then the parent or the entry is written, until the
// entry reaches the root or a parent that is not smaller. Remove: fetch the last entry, then per level
// examined read left, read right (if present) and write, until a leaf is found, then finish;
// these steps are set by the single memory read port and the shared key comparator.
// Full or empty cases and a remove of the only entry go straight to the result.
// Reset clears the entry count, the sequencer registers and the output register, not the entry
// memory; a finished item waits in the output register while a new item is taken.
module max_heap_priority_queue #(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic signed [31:0] key,
    input  logic [31:0]        tag,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] removed_key,
    output logic [31:0]        removed_tag,
    output logic               top_valid,
    output logic signed [31:0] top_key,
    output logic [31:0]        top_tag,
    output logic [10:0]        entry_total
);
    import mhpq_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic          res_valid, res_ready;
    mhpq_res_t     res;
    logic          wr_en, rd_en;
    logic [AW-1:0] waddr, raddr;
    mhpq_entry_t   wdata, rdata;
    logic          out_valid_reg, out_valid_next;
    mhpq_res_t     out_reg, out_next;

    mhpq_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .key       (key),
        .tag       (tag),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .waddr     (waddr),
        .wdata     (wdata),
        .rd_en     (rd_en),
        .raddr     (raddr),
        .rdata     (rdata)
    );

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .wr_en (wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .rd_en (rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Load the output register when it is empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // Drive the result ports
    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign removed_key = out_reg.removed_key;
    assign removed_tag = out_reg.removed_tag;
    assign top_valid   = out_reg.top_valid;
    assign top_key     = out_reg.top_key;
    assign top_tag     = out_reg.top_tag;
    assign entry_total = out_reg.entry_total;

endmodule

@@ hw/rtl/mhpq_ram.sv @@
// Heap entry storage: one write port and one registered read port.
module mhpq_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        waddr,
    input  mhpq_pkg::mhpq_entry_t wdata,
    input  logic                 rd_en,
    input  logic [AW-1:0]        raddr,
    output mhpq_pkg::mhpq_entry_t rdata
);
    import mhpq_pkg::*;

    mhpq_entry_t mem [DEPTH];
    mhpq_entry_t rdata_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one entry, data valid next cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/mhpq_seq.sv @@
// Sift sequencer with one shared signed key comparator.
module mhpq_seq #(
    parameter int unsigned CAPACITY = 1024,
    parameter int unsigned AW       = 10,
    parameter int unsigned CW       = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic signed [31:0]    key,
    input  logic [31:0]           tag,
    output logic                  res_valid,
    input  logic                  res_ready,
    output mhpq_pkg::mhpq_res_t   res,
    output logic                  wr_en,
    output logic [AW-1:0]         waddr,
    output mhpq_pkg::mhpq_entry_t wdata,
    output logic                  rd_en,
    output logic [AW-1:0]         raddr,
    input  mhpq_pkg::mhpq_entry_t rdata
);
    import mhpq_pkg::*;

    localparam int unsigned IW = AW + 2;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_L,
        S_DN_LC,
        S_DN_RC,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [AW-1:0]      par_reg, par_next;
    mhpq_entry_t        cur_reg, cur_next;
    mhpq_entry_t        best_reg, best_next;
    logic               best_cur_reg, best_cur_next;
    mhpq_entry_t        top_reg, top_next;
    mhpq_entry_t        removed_reg, removed_next;
    logic [1:0]         status_reg, status_next;

    logic [IW-1:0]      pos_ext, lc_idx, rc_idx, count_ext;
    logic [AW-1:0]      pos_m1, parent_idx;
    logic [CW-1:0]      count_m1;
    logic [CW+TOTAL_W-1:0] count_wide;
    logic signed [31:0] cmp_lhs, cmp_rhs;
    logic               cmp_gt;
    mhpq_entry_t        cand;
    logic               cand_cur;
    logic [AW-1:0]      cand_idx;
    logic               rc_in;

    // Index arithmetic
    assign pos_ext    = {2'b00, pos_reg};
    assign lc_idx     = (pos_ext << 1) + IW'(1);
    assign rc_idx     = (pos_ext << 1) + IW'(2);
    assign count_ext  = {{(IW-CW){1'b0}}, count_reg};
    assign pos_m1     = pos_reg - AW'(1);
    assign parent_idx = pos_m1 >> 1;
    assign count_m1   = count_reg - CW'(1);
    assign count_wide = {{TOTAL_W{1'b0}}, count_reg};
    assign rc_in      = rc_idx < count_ext;

    // Select operands of the shared comparator
    always_comb
    begin
        cmp_lhs = rdata.key;
        cmp_rhs = best_reg.key;
        case (state_reg)
            S_UP_CMP:
            begin
                cmp_lhs = cur_reg.key;
                cmp_rhs = rdata.key;
            end
            S_DN_LC:
            begin
                cmp_lhs = rdata.key;
                cmp_rhs = cur_reg.key;
            end
            default:
            begin
                cmp_lhs = rdata.key;
                cmp_rhs = best_reg.key;
            end
        endcase
    end

    assign cmp_gt = cmp_lhs > cmp_rhs;

    // Pick the larger of the entries seen at this level
    always_comb
    begin
        if (state_reg == S_DN_RC)
        begin
            cand     = cmp_gt ? rdata : best_reg;
            cand_cur = cmp_gt ? 1'b0 : best_cur_reg;
            cand_idx = cmp_gt ? rc_idx[AW-1:0] : lc_idx[AW-1:0];
        end
        else
        begin
            cand     = cmp_gt ? rdata : cur_reg;
            cand_cur = !cmp_gt;
            cand_idx = lc_idx[AW-1:0];
        end
    end

    // Sequence the sift steps
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        par_next      = par_reg;
        cur_next      = cur_reg;
        best_next     = best_reg;
        best_cur_next = best_cur_reg;
        removed_next  = removed_reg;
        status_next   = status_reg;
        wr_en         = 1'b0;
        waddr         = pos_reg;
        wdata         = cur_reg;
        rd_en         = 1'b0;
        raddr         = parent_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    status_next  = ST_OK;
                    removed_next = '0;
                    pos_next     = '0;
                    if (opcode == OP_INSERT)
                    begin
                        if (count_reg == CAP_CNT)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cur_next.key = key;
                            cur_next.tag = tag;
                            pos_next     = count_reg[AW-1:0];
                            count_next   = count_reg + CW'(1);
                            state_next   = S_UP_CHK;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            removed_next = top_reg;
                            count_next   = count_m1;
                            if (count_reg == CW'(1))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                raddr      = count_m1[AW-1:0];
                                state_next = S_DN_LOAD;
                            end
                        end
                    end
                end
            end
            S_UP_CHK:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    raddr      = parent_idx;
                    par_next   = parent_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                wr_en = 1'b1;
                if (cmp_gt)
                begin
                    wdata      = rdata;
                    pos_next   = par_reg;
                    state_next = S_UP_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DN_LOAD:
            begin
                cur_next   = rdata;
                state_next = S_DN_L;
            end
            S_DN_L:
            begin
                if (lc_idx >= count_ext)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    raddr      = lc_idx[AW-1:0];
                    state_next = S_DN_LC;
                end
            end
            S_DN_LC, S_DN_RC:
            begin
                if (state_reg == S_DN_LC && rc_in)
                begin
                    best_next     = cand;
                    best_cur_next = cand_cur;
                    rd_en         = 1'b1;
                    raddr         = rc_idx[AW-1:0];
                    state_next    = S_DN_RC;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (cand_cur)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        wdata      = cand;
                        pos_next   = cand_idx;
                        state_next = S_DN_L;
                    end
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Track the root entry as it is written
    always_comb
    begin
        top_next = top_reg;
        if (wr_en && waddr == '0)
        begin
            top_next = wdata;
        end
    end

    // Hold state and registered values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pos_reg      <= '0;
            par_reg      <= '0;
            cur_reg      <= '0;
            best_reg     <= '0;
            best_cur_reg <= 1'b0;
            top_reg      <= '0;
            removed_reg  <= '0;
            status_reg   <= ST_OK;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            par_reg      <= par_next;
            cur_reg      <= cur_next;
            best_reg     <= best_next;
            best_cur_reg <= best_cur_next;
            top_reg      <= top_next;
            removed_reg  <= removed_next;
            status_reg   <= status_next;
        end
    end

    // Drive handshake and result
    assign in_ready        = state_reg == S_IDLE;
    assign res_valid       = state_reg == S_DONE;
    assign res.status      = status_reg;
    assign res.removed_key = removed_reg.key;
    assign res.removed_tag = removed_reg.tag;
    assign res.top_valid   = count_reg != '0;
    assign res.top_key     = (count_reg != '0) ? top_reg.key : '0;
    assign res.top_tag     = (count_reg != '0) ? top_reg.tag : '0;
    assign res.entry_total = count_wide[TOTAL_W-1:0];

endmodule

@@ test/heap_scoreboard_pkg.sv @@
// Scoreboard class that predicts and checks max-heap priority queue results.
package heap_scoreboard_pkg;

    import mhpq_pkg::*;

    localparam int unsigned HEAP_DEPTH   = 1024;
    localparam int unsigned REPORT_LIMIT = 10;

    class heap_scoreboard;

        mhpq_entry_t         slots [HEAP_DEPTH];
        int unsigned         held;
        mhpq_res_t           expected_q [$];
        int unsigned         mismatch_count;

        function new();
            held           = 0;
            mismatch_count = 0;
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        // Exchange two heap slots
        function void swap_slots(int unsigned a, int unsigned b);
            mhpq_entry_t hold_entry;
            hold_entry = slots[a];
            slots[a]   = slots[b];
            slots[b]   = hold_entry;
        endfunction

        // Move an entry up while it is strictly larger than its parent
        function void climb(int unsigned start);
            int unsigned pos;
            int unsigned parent;
            pos = start;
            while (pos > 0)
            begin
                parent = (pos - 1) / 2;
                if ($signed(slots[pos].key) > $signed(slots[parent].key))
                begin
                    swap_slots(pos, parent);
                    pos = parent;
                end
                else
                begin
                    break;
                end
            end
        endfunction

        // Move an entry down toward the strictly larger child, left first
        function void sink(int unsigned start);
            int unsigned pos;
            int unsigned best;
            int unsigned lc;
            int unsigned rc;
            pos = start;
            forever
            begin
                best = pos;
                lc   = 2 * pos + 1;
                rc   = 2 * pos + 2;
                if (lc < held && $signed(slots[lc].key) > $signed(slots[best].key))
                    best = lc;
                if (rc < held && $signed(slots[rc].key) > $signed(slots[best].key))
                    best = rc;
                if (best == pos)
                    break;
                swap_slots(pos, best);
                pos = best;
            end
        endfunction

        // Apply one accepted item to the heap and queue its expected result
        function void note_item(logic op, logic signed [31:0] k, logic [31:0] t);
            mhpq_res_t want;
            want        = '0;
            want.status = ST_OK;
            if (op == OP_INSERT)
            begin
                if (held >= HEAP_DEPTH)
                begin
                    want.status = ST_FULL;
                end
                else
                begin
                    slots[held].key = k;
                    slots[held].tag = t;
                    held++;
                    climb(held - 1);
                end
            end
            else
            begin
                if (held == 0)
                begin
                    want.status = ST_EMPTY;
                end
                else
                begin
                    want.removed_key = slots[0].key;
                    want.removed_tag = slots[0].tag;
                    slots[0]         = slots[held - 1];
                    held--;
                    sink(0);
                end
            end
            if (held > 0)
            begin
                want.top_valid = 1'b1;
                want.top_key   = slots[0].key;
                want.top_tag   = slots[0].tag;
            end
            want.entry_total = TOTAL_W'(held);
            expected_q.push_back(want);
        endfunction

        // Count a mismatch and show the first few
        function void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        endfunction

        // Compare one result against the oldest expectation
        function void check_result(mhpq_res_t got);
            mhpq_res_t want;
            if (expected_q.size() == 0)
            begin
                flag_mismatch("unexpected result entry_total", '0, 64'(got.entry_total));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                flag_mismatch("status", 64'(want.status), 64'(got.status));
            if (got.removed_key !== want.removed_key)
                flag_mismatch("removed_key", 64'(want.removed_key), 64'(got.removed_key));
            if (got.removed_tag !== want.removed_tag)
                flag_mismatch("removed_tag", 64'(want.removed_tag), 64'(got.removed_tag));
            if (got.top_valid !== want.top_valid)
                flag_mismatch("top_valid", 64'(want.top_valid), 64'(got.top_valid));
            if (got.top_key !== want.top_key)
                flag_mismatch("top_key", 64'(want.top_key), 64'(got.top_key));
            if (got.top_tag !== want.top_tag)
                flag_mismatch("top_tag", 64'(want.top_tag), 64'(got.top_tag));
            if (got.entry_total !== want.entry_total)
                flag_mismatch("entry_total", 64'(want.entry_total), 64'(got.entry_total));
        endfunction

    endclass

endpackage

@@ test/max_heap_priority_queue_test.sv @@
// Self-checking testbench for the max-heap priority queue.
module max_heap_priority_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mhpq_pkg::*;
    import heap_scoreboard_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int IDLE_PCT     = 15;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic               opcode      = OP_INSERT;
    logic signed [31:0] key         = '0;
    logic [31:0]        tag         = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] removed_key;
    logic [31:0]        removed_tag;
    logic               top_valid;
    logic signed [31:0] top_key;
    logic [31:0]        top_tag;
    logic [10:0]        entry_total;

    int             send_idle_pct  = IDLE_PCT;
    int             recv_stall_pct = IDLE_PCT;
    int             cycle_count    = 0;
    heap_scoreboard sb             = new();

    max_heap_priority_queue #(
        .CAPACITY (HEAP_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .key         (key),
        .tag         (tag),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .removed_key (removed_key),
        .removed_tag (removed_tag),
        .top_valid   (top_valid),
        .top_key     (top_key),
        .top_tag     (top_tag),
        .entry_total (entry_total)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL max_heap_priority_queue");
            $finish;
        end
    end

    // Collect results and stall the output at random
    always @(posedge clk)
    begin : collect
        mhpq_res_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.status      = status;
            got.removed_key = removed_key;
            got.removed_tag = removed_tag;
            got.top_valid   = top_valid;
            got.top_key     = top_key;
            got.top_tag     = top_tag;
            got.entry_total = entry_total;
            sb.check_result(got);
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(logic op, logic signed [31:0] k, logic [31:0] t);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        key      <= k;
        tag      <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(op, k, t);
    endtask

    // Hold off the sender until every result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // Pick a key: full range, a narrow band for ties, extremes or a mid range
    function automatic logic signed [31:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return $urandom;
        else if (sel < 60)
            return $signed($urandom_range(0, 7)) - 4;
        else if (sel < 70)
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        else
            return $signed($urandom_range(0, 2000)) - 1000;
    endfunction

    // Send a random item with the given chance of a remove
    task automatic send_random(int remove_pct);
        if ($urandom_range(0, 99) < remove_pct)
            send_item(OP_REMOVE, $urandom, $urandom);
        else
            send_item(OP_INSERT, pick_key(), $urandom);
    endtask

    initial
    begin : stimulus
        int n;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: remove on empty, key extremes, equal keys
        send_item(OP_REMOVE, 32'sh1234_5678, 32'h9ABC_DEF0);
        send_item(OP_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'sh8000_0000, 32'h0000_0000);
        send_item(OP_INSERT, 32'sh0000_0000, 32'h5555_5555);
        send_item(OP_INSERT, -32'sd1,        32'hAAAA_AAAA);
        send_item(OP_INSERT, 32'sd5,         32'h0000_0001);
        send_item(OP_INSERT, 32'sd5,         32'h0000_0002);
        send_item(OP_INSERT, 32'sh7FFF_FFFF, 32'h0000_1234);
        repeat (7) send_item(OP_REMOVE, $urandom, $urandom);
        send_item(OP_REMOVE, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);

        // Directed: equal children, left one must win on the way down
        send_item(OP_INSERT, 32'sd20, 32'h0000_0020);
        send_item(OP_INSERT, 32'sd8,  32'h0000_00A8);
        send_item(OP_INSERT, 32'sd8,  32'h0000_00B8);
        send_item(OP_INSERT, 32'sd3,  32'h0000_0003);
        repeat (5) send_item(OP_REMOVE, 32'sh0, 32'h0);

        wait_drained();

        // Mixed traffic near empty
        for (n = 0; n < 100; n++)
            send_random(45);

        // Fill to capacity, with a calm stretch in the middle
        n = 0;
        while (sb.held < HEAP_DEPTH)
        begin
            if (n == 300)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            if (n == 500)
            begin
                send_idle_pct  = IDLE_PCT;
                recv_stall_pct = IDLE_PCT;
            end
            send_random(3);
            n++;
        end

        // Hammer the full heap
        for (n = 0; n < 30; n++)
            send_random(30);

        wait_drained();

        // Mixed traffic on a deep heap
        for (n = 0; n < 200; n++)
            send_random(55);

        // Drain and finish
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.outstanding() == 0)
            $display("PASS max_heap_priority_queue");
        else
            $display("FAIL max_heap_priority_queue");
        $finish;
    end

endmodule
